FILE: rtl/core/nfsa_pkg.sv
// shared constants and controller/datapath interface types for the slot allocator
`default_nettype none

package nfsa_pkg;

	localparam int unsigned SLOTS_DEF = 1024;
	localparam int unsigned CNT_W = 11;
	localparam int unsigned IDX_W = 10;
	localparam int unsigned ST_W = 2;
	localparam int unsigned WORD_BITS = 64;
	localparam int unsigned WORD_LSB = 6;

	localparam logic [CNT_W-1:0] SLOT_COUNT_RST = 11'd1024;

	localparam logic CMD_ALLOC = 1'b0;

	localparam logic [ST_W-1:0] ST_GRANTED = 2'd0;
	localparam logic [ST_W-1:0] ST_BUSY = 2'd1;
	localparam logic [ST_W-1:0] ST_RELEASED = 2'd2;
	localparam logic [ST_W-1:0] ST_REJECTED = 2'd3;

	typedef struct packed {
		logic load;
		logic init;
		logic scan;
		logic rel_rd;
		logic rel_wr;
		logic pend_load;
		logic [ST_W-1:0] pend_status;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic is_release;
		logic n_zero;
		logic in_range;
		logic hit;
		logic miss;
		logic out_free;
	} dp_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/nfsa_ctrl.sv
// controller state machine sequencing allocate and release requests
`default_nettype none

module nfsa_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  nfsa_pkg::dp_sts_t sts,
	output nfsa_pkg::dp_cmd_t cmd
);
	import nfsa_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_REL_WR,
		S_RESULT
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
				if (in_valid) begin
					state_nxt = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.is_release) begin
					if (sts.in_range) begin
						cmd.rel_rd = 1'b1;
						state_nxt = S_REL_WR;
					end else begin
						cmd.pend_load = 1'b1;
						cmd.pend_status = ST_REJECTED;
						state_nxt = S_RESULT;
					end
				end else if (sts.n_zero) begin
					cmd.pend_load = 1'b1;
					cmd.pend_status = ST_BUSY;
					state_nxt = S_RESULT;
				end else begin
					cmd.init = 1'b1;
					state_nxt = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit) begin
					cmd.pend_load = 1'b1;
					cmd.pend_status = ST_GRANTED;
					state_nxt = S_RESULT;
				end else if (sts.miss) begin
					cmd.pend_load = 1'b1;
					cmd.pend_status = ST_BUSY;
					state_nxt = S_RESULT;
				end
			end
			S_REL_WR: begin
				cmd.rel_wr = 1'b1;
				cmd.pend_load = 1'b1;
				cmd.pend_status = ST_RELEASED;
				state_nxt = S_RESULT;
			end
			S_RESULT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/nfsa_dpath.sv
// datapath: in-use map memory, word scan, search pointer and result registers
`default_nettype none

module nfsa_dpath #(
	parameter int unsigned SLOTS = nfsa_pkg::SLOTS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [nfsa_pkg::CNT_W-1:0] cfg_wdata,
	input  wire logic command,
	input  wire logic [nfsa_pkg::IDX_W-1:0] slot_index,
	input  nfsa_pkg::dp_cmd_t cmd,
	output nfsa_pkg::dp_sts_t sts,
	input  wire logic out_ready,
	output logic out_valid,
	output logic [nfsa_pkg::ST_W-1:0] status,
	output logic [nfsa_pkg::IDX_W-1:0] granted_index
);
	import nfsa_pkg::*;

	localparam int unsigned WB = WORD_BITS;
	localparam int unsigned BW = WORD_LSB;
	localparam int unsigned ROWS = (SLOTS + WB - 1) / WB;
	localparam int unsigned RW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int unsigned PW = RW + BW;
	localparam int unsigned NW = $clog2(SLOTS + 1);
	localparam int unsigned LW0 = (NW > PW) ? NW : PW;
	localparam int unsigned LW1 = (LW0 > IDX_W) ? LW0 : IDX_W;
	localparam int unsigned LW = (LW1 > CNT_W) ? LW1 : CNT_W;

	logic [CNT_W-1:0] slot_count_q;
	logic cmd_q;
	logic [IDX_W-1:0] idx_q;
	logic [PW-1:0] ss_q;
	logic [RW-1:0] wi_q;
	logic [RW-1:0] startw_q;
	logic [RW-1:0] lastw_q;
	logic [BW-1:0] startb_q;
	logic [BW-1:0] lastb_q;
	logic wrap_i_q;
	logic idone_q;
	logic v_s1;
	logic [RW-1:0] w_s1;
	logic wrap_s1;
	logic last_s1;
	logic [WB-1:0] rd_s1;
	logic rv_s1;
	logic [WB-1:0] mem [ROWS];
	logic [ROWS-1:0] rv_q;
	logic [ST_W-1:0] pend_status_q;
	logic [IDX_W-1:0] pend_idx_q;
	logic out_valid_q;
	logic [ST_W-1:0] status_q;
	logic [IDX_W-1:0] granted_q;

	logic [NW-1:0] n;
	logic [PW-1:0] start_eff;
	logic [LW-1:0] nm1;
	logic [PW-1:0] idx_pos;
	logic [RW-1:0] nxt_w;
	logic issue;
	logic ren;
	logic [RW-1:0] raddr;
	logic [WB-1:0] word;
	logic [WB-1:0] allow;
	logic [WB-1:0] free;
	logic [BW-1:0] fb;
	logic found;
	logic hit;
	logic [PW-1:0] hit_pos;
	logic [LW-1:0] pinc;
	logic wen;
	logic [RW-1:0] waddr;
	logic [WB-1:0] wdata;

	// effective slot count, capped at the built capacity
	always_comb begin
		if (LW'(slot_count_q) > LW'(SLOTS)) begin
			n = NW'(SLOTS);
		end else begin
			n = NW'(slot_count_q);
		end
	end

	assign start_eff = (LW'(ss_q) < LW'(n)) ? ss_q : '0;
	assign nm1 = LW'(n) - LW'(1);
	assign idx_pos = PW'(idx_q);
	assign nxt_w = (wi_q == lastw_q) ? '0 : wi_q + RW'(1);
	assign issue = cmd.scan & ~idone_q;
	assign ren = issue | cmd.rel_rd;
	assign raddr = cmd.rel_rd ? idx_pos[PW-1:BW] : wi_q;

	// map word as read, rows never written read as all free
	assign word = rv_s1 ? rd_s1 : '0;

	always_comb begin
		for (int b = 0; b < WB; b++) begin
			allow[b] = ((w_s1 != lastw_q) || (BW'(b) <= lastb_q))
				&& ((w_s1 != startw_q)
				|| (wrap_s1 ? (BW'(b) < startb_q) : (BW'(b) >= startb_q)));
		end
	end

	assign free = ~word & allow;
	assign found = |free;

	always_comb begin
		fb = '0;
		for (int b = WB - 1; b >= 0; b--) begin
			if (free[b]) begin
				fb = BW'(b);
			end
		end
	end

	assign hit = cmd.scan & v_s1 & found;
	assign hit_pos = {w_s1, fb};
	assign pinc = LW'(hit_pos) + LW'(1);

	assign wen = hit | cmd.rel_wr;
	assign waddr = cmd.rel_wr ? idx_pos[PW-1:BW] : w_s1;
	assign wdata = cmd.rel_wr ? (word & ~(WB'(1) << idx_pos[BW-1:0]))
		: (word | (WB'(1) << fb));

	assign sts.is_release = (cmd_q != CMD_ALLOC);
	assign sts.n_zero = (n == '0);
	assign sts.in_range = (LW'(idx_q) < LW'(n));
	assign sts.hit = hit;
	assign sts.miss = cmd.scan & v_s1 & last_s1 & ~found;
	assign sts.out_free = ~out_valid_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= SLOT_COUNT_RST;
			ss_q <= '0;
			rv_q <= '0;
			rv_s1 <= 1'b0;
			v_s1 <= 1'b0;
			wrap_i_q <= 1'b0;
			idone_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				slot_count_q <= cfg_wdata;
			end
			if (hit) begin
				ss_q <= (pinc >= LW'(n)) ? '0 : PW'(pinc);
			end
			if (wen) begin
				rv_q[waddr] <= 1'b1;
			end
			if (ren) begin
				rv_s1 <= rv_q[raddr];
			end
			v_s1 <= issue;
			if (cmd.init) begin
				wrap_i_q <= 1'b0;
				idone_q <= 1'b0;
			end else if (issue) begin
				if (nxt_w == startw_q) begin
					wrap_i_q <= 1'b1;
				end
				if (wrap_i_q && (wi_q == startw_q)) begin
					idone_q <= 1'b1;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= command;
			idx_q <= slot_index;
		end
		if (cmd.init) begin
			wi_q <= start_eff[PW-1:BW];
			startw_q <= start_eff[PW-1:BW];
			startb_q <= start_eff[BW-1:0];
			lastw_q <= nm1[PW-1:BW];
			lastb_q <= nm1[BW-1:0];
		end else if (issue) begin
			wi_q <= nxt_w;
		end
		w_s1 <= wi_q;
		wrap_s1 <= wrap_i_q;
		last_s1 <= wrap_i_q && (wi_q == startw_q);
		if (cmd.pend_load) begin
			pend_status_q <= cmd.pend_status;
			pend_idx_q <= (cmd.pend_status == ST_GRANTED) ? IDX_W'(hit_pos) : '0;
		end
		if (cmd.out_load) begin
			status_q <= pend_status_q;
			granted_q <= pend_idx_q;
		end
	end

	// map memory, one word write and one registered word read per cycle
	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
		if (ren) begin
			rd_s1 <= mem[raddr];
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign granted_index = granted_q;

endmodule

`default_nettype wire

FILE: rtl/core/next_fit_slot_allocator_unit.sv
// Next-fit slot allocator: one request at a time, one result per request. The
// in-use map is held as 64-bit words in a memory with one valid flip-flop per
// word, so reset frees every slot at once with no clearing pass. An allocate
// scans the map one word per cycle from the search pointer, wrapping at the
// configured slot count, and reads the start word a second time for the slots
// below the pointer. A release reads the map word of its slot and writes it
// back with the slot cleared; a rejected release or an allocate with a zero
// slot count goes straight to the result. The block returns to idle once the
// result is loaded, and only then takes the next request. The next request is
// taken while a finished result waits at the output register. Write
// slot_count only while no request is in flight.
`default_nettype none

module next_fit_slot_allocator_unit #(
	parameter int unsigned SLOTS = nfsa_pkg::SLOTS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [nfsa_pkg::CNT_W-1:0] cfg_wdata,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic command,
	input  wire logic [nfsa_pkg::IDX_W-1:0] slot_index,
	output logic out_valid,
	input  wire logic out_ready,
	output logic [nfsa_pkg::ST_W-1:0] status,
	output logic [nfsa_pkg::IDX_W-1:0] granted_index
);
	import nfsa_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	nfsa_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts(sts),
		.cmd(cmd)
	);

	nfsa_dpath #(
		.SLOTS(SLOTS)
	) u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.command(command),
		.slot_index(slot_index),
		.cmd(cmd),
		.sts(sts),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.status(status),
		.granted_index(granted_index)
	);

endmodule

`default_nettype wire

FILE: rtl/core/nfsa_props.sv
// port-level assertions for the slot allocator and their bind to the top level
`default_nettype none

module nfsa_props (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [nfsa_pkg::ST_W-1:0] status,
	input wire logic [nfsa_pkg::IDX_W-1:0] granted_index
);
	import nfsa_pkg::*;

	// result holds until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(granted_index))
		else $error("result changed before transfer");

	// only a grant carries an index
	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_GRANTED) |-> granted_index == '0)
		else $error("index on a non-grant result");

	// one request at a time
	a_one_at_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	// a new result appears only after a request was in flight
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without a request in flight");

endmodule

bind next_fit_slot_allocator_unit nfsa_props u_props (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.status(status),
	.granted_index(granted_index)
);

`default_nettype wire
